[rtl/fcdma_pkg.sv]
// Package for the four-channel DMA controller: widths, codes and payload types.
// No dependencies.
package fcdma_pkg;

    localparam int CHANNELS_DEF = 4;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_FIFO  = 2'd3
    } mode_t;

    localparam logic [3:0] FLD_SRC_LO = 4'd0;
    localparam logic [3:0] FLD_SRC_HI = 4'd2;
    localparam logic [3:0] FLD_DST_LO = 4'd4;
    localparam logic [3:0] FLD_DST_HI = 4'd6;
    localparam logic [3:0] FLD_COUNT  = 4'd8;
    localparam logic [3:0] FLD_CTRL   = 4'd10;

    localparam logic [1:0] TRIG_IMM  = 2'd0;
    localparam logic [1:0] TRIG_VBL  = 2'd1;
    localparam logic [1:0] TRIG_HBL  = 2'd2;
    localparam logic [1:0] TRIG_FIFO = 2'd3;

    localparam logic [1:0] ADDR_FIXED  = 2'd2;
    localparam logic [1:0] ADDR_RELOAD = 2'd3;

    localparam int CTRL_ENABLE = 15;
    localparam int CTRL_WORD   = 10;
    localparam int CTRL_REPEAT = 9;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  reg_offset;
        logic [15:0] write_data;
        logic [15:0] tick_flags;
        logic        fifo_select;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        xfer_valid;
        logic [1:0]  channel;
        logic [31:0] src_start;
        logic [31:0] dst_start;
        logic [16:0] beat_count;
        logic        word_unit;
        logic        src_increment;
        logic        dst_increment;
        logic        to_fifo;
        logic [18:0] cycles;
        logic        last;
    } out_item_t;

endpackage

[rtl/fcdma_if.sv]
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type given as a type parameter.
interface fcdma_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/fcdma_addr.sv]
// Shared address adder: end address = base + beats * unit (a shift), or base + 16 for a FIFO burst.
// Depends on fcdma_pkg.
module fcdma_addr
    import fcdma_pkg::*;
(
    input  logic [31:0] base,
    input  logic [16:0] beats,
    input  logic        word,
    input  logic        fifo,
    output logic [31:0] sum
);
    logic [31:0] step;
    always_comb
    begin
        if (fifo)
            step = 32'd16;
        else if (word)
            step = {13'd0, beats, 2'b00};
        else
            step = {14'd0, beats, 1'b0};
        sum = base + step;
    end
endmodule

[rtl/four_channel_dma_controller.sv]
// Four-channel DMA controller register file and transfer sequencer.
// A read or write result is registered in the decode state after the word is taken; a tick or
// FIFO request scans one channel per cycle while no result is pending, and each transfer runs
// through the source, destination and output states. A new word is taken only back in idle
// with no result pending, so output stalls hold the next word back.
// Reset: asynchronous active-low rst_n clears all channel state to zero.
// Depends on fcdma_pkg, fcdma_if, fcdma_addr.
module four_channel_dma_controller
    import fcdma_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    fcdma_if.sink   in_ch,
    fcdma_if.source out_ch
);
    localparam int CW = $clog2(CHANNELS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEC  = 6'b000010,
        S_SCAN = 6'b000100,
        S_SRC  = 6'b001000,
        S_DST  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] src_reg [CHANNELS];
    logic [31:0] dst_reg [CHANNELS];
    logic [31:0] rld_reg [CHANNELS];
    logic [15:0] cnt_reg [CHANNELS];
    logic [15:0] crl_reg [CHANNELS];
    logic [15:0] ctl_reg [CHANNELS];
    logic [CHANNELS-1:0] en_reg;

    in_item_t  item_reg;
    out_item_t res_reg;
    logic      res_valid_reg;
    logic [CW-1:0] cur_reg;   // channel under scan or transfer
    logic      fifo_xfer_reg; // transfer in progress is a FIFO burst
    logic      done_reg;      // scan reached its end
    logic      any_reg;       // some result already given for this word
    logic      imm_reg;       // transfer started by an enable write

    // Decode of the held word; offsets past the window fold back onto
    // channels 0 and 1, where reads return the control word and writes are ignored
    logic [CW-1:0] dec_ch;
    logic [3:0]    dec_rel;
    logic [5:0]    off;
    always_comb
    begin
        off = item_reg.reg_offset;
        if (off >= 6'd60)
            dec_ch = CW'(1);
        else if (off >= 6'd48)
            dec_ch = CW'(0);
        else if (off >= 6'd36)
            dec_ch = CW'(3);
        else if (off >= 6'd24)
            dec_ch = CW'(2);
        else if (off >= 6'd12)
            dec_ch = CW'(1);
        else
            dec_ch = CW'(0);
        if (off >= 6'd48)
            dec_rel = 4'hF;
        else
            dec_rel = 4'(off - 6'd12 * {4'd0, 2'(dec_ch)});
    end

    // Current channel view
    logic [15:0] cc;
    logic [1:0]  sc, dc, trig;
    logic        cword, sinc, dinc;
    logic [16:0] beats;
    always_comb
    begin
        cc    = ctl_reg[cur_reg];
        sc    = cc[8:7];
        dc    = cc[6:5];
        trig  = cc[13:12];
        cword = cc[CTRL_WORD];
        sinc  = (sc != ADDR_FIXED);
        dinc  = (dc != ADDR_FIXED);
        if (cnt_reg[cur_reg] != 16'd0)
            beats = {1'b0, cnt_reg[cur_reg]};
        else if (cur_reg == CW'(0))
            beats = 17'h04000;
        else
            beats = 17'h10000;
    end

    // Channels that fire on this tick, and whether any fires above the current one
    logic [CHANNELS-1:0] tick_hit;
    logic                later_hit;
    always_comb
    begin
        later_hit = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            case (ctl_reg[c][13:12])
                TRIG_IMM: tick_hit[c] = en_reg[c] && (item_reg.tick_flags != 16'd0);
                TRIG_VBL: tick_hit[c] = en_reg[c] && item_reg.tick_flags[0];
                TRIG_HBL: tick_hit[c] = en_reg[c] && item_reg.tick_flags[1];
                default:  tick_hit[c] = 1'b0;
            endcase
            if (tick_hit[c] && (CW'(c) > cur_reg))
                later_hit = 1'b1;
        end
    end

    // Does the scanned channel fire on this tick or FIFO request?
    logic fire;
    always_comb
    begin
        if (item_reg.mode == MODE_FIFO)
            fire = en_reg[cur_reg] && (trig == TRIG_FIFO);
        else
            fire = tick_hit[cur_reg];
    end

    // Shared adder: source in S_SRC, destination in S_DST
    logic [31:0] add_base, add_sum;
    assign add_base = (state_reg == S_DST) ? dst_reg[cur_reg] : src_reg[cur_reg];
    fcdma_addr u_addr (
        .base  (add_base),
        .beats (beats),
        .word  (cword),
        .fifo  (fifo_xfer_reg),
        .sum   (add_sum)
    );

    logic last_scan;
    always_comb
    begin
        if (item_reg.mode == MODE_FIFO)
            last_scan = (cur_reg == CW'(2 + {1'b0, item_reg.fifo_select}));
        else
            last_scan = (cur_reg == CW'(CHANNELS - 1));
    end

    assign in_ch.ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign out_ch.valid = res_valid_reg;
    assign out_ch.data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_DEC;
            S_DEC:  state_next = S_IDLE;
            S_SCAN: state_next = S_SCAN;
            S_SRC:  state_next = S_DST;
            S_DST:  state_next = S_OUT;
            S_OUT:  state_next = S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            item_reg      <= '0;
            res_reg       <= '0;
            en_reg        <= '0;
            cur_reg       <= '0;
            fifo_xfer_reg <= 1'b0;
            done_reg      <= 1'b0;
            any_reg       <= 1'b0;
            imm_reg       <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                src_reg[i] <= '0;
                dst_reg[i] <= '0;
                rld_reg[i] <= '0;
                cnt_reg[i] <= '0;
                crl_reg[i] <= '0;
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        item_reg  <= in_ch.data;
                        state_reg <= state_next;
                    end
                end
                S_DEC:
                begin
                    res_reg <= '0;
                    any_reg <= 1'b0;
                    imm_reg <= 1'b0;
                    state_reg <= S_IDLE;
                    case (item_reg.mode)
                        MODE_READ:
                        begin
                            case (dec_rel)
                                FLD_SRC_LO: res_reg.read_data <= src_reg[dec_ch][15:0];
                                FLD_SRC_HI: res_reg.read_data <= src_reg[dec_ch][31:16];
                                FLD_DST_LO: res_reg.read_data <= dst_reg[dec_ch][15:0];
                                FLD_DST_HI: res_reg.read_data <= dst_reg[dec_ch][31:16];
                                FLD_COUNT:  res_reg.read_data <= cnt_reg[dec_ch];
                                default:    res_reg.read_data <= ctl_reg[dec_ch];
                            endcase
                            res_reg.last  <= 1'b1;
                            res_valid_reg <= 1'b1;
                        end
                        MODE_WRITE:
                        begin
                            res_reg.last  <= 1'b1;
                            res_valid_reg <= 1'b1;
                            case (dec_rel)
                                FLD_SRC_LO: src_reg[dec_ch][15:0]  <= item_reg.write_data;
                                FLD_SRC_HI: src_reg[dec_ch][31:16] <= item_reg.write_data;
                                FLD_DST_LO: dst_reg[dec_ch][15:0]  <= item_reg.write_data;
                                FLD_DST_HI: dst_reg[dec_ch][31:16] <= item_reg.write_data;
                                FLD_COUNT:
                                begin
                                    crl_reg[dec_ch] <= item_reg.write_data;
                                    cnt_reg[dec_ch] <= item_reg.write_data;
                                end
                                FLD_CTRL:
                                begin
                                    ctl_reg[dec_ch] <= item_reg.write_data;
                                    if (!item_reg.write_data[CTRL_ENABLE])
                                        en_reg[dec_ch] <= 1'b0;
                                    else if (!ctl_reg[dec_ch][CTRL_ENABLE])
                                    begin
                                        // rising enable: reload count, latch destination
                                        en_reg[dec_ch]  <= 1'b1;
                                        cnt_reg[dec_ch] <= crl_reg[dec_ch];
                                        rld_reg[dec_ch] <= dst_reg[dec_ch];
                                        if (item_reg.write_data[13:12] == TRIG_IMM)
                                        begin
                                            // hold the result; run the transfer
                                            res_valid_reg <= 1'b0;
                                            imm_reg       <= 1'b1;
                                            fifo_xfer_reg <= 1'b0;
                                            cur_reg       <= dec_ch;
                                            state_reg     <= S_SRC;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default:
                        begin
                            // tick or FIFO request: start scan
                            done_reg  <= 1'b0;
                            cur_reg   <= (item_reg.mode == MODE_FIFO)
                                         ? CW'(1 + {1'b0, item_reg.fifo_select}) : '0;
                            state_reg <= S_SCAN;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    if (!res_valid_reg || (out_ch.valid && out_ch.ready))
                    begin
                        if (fire)
                        begin
                            fifo_xfer_reg <= (item_reg.mode == MODE_FIFO);
                            state_reg     <= S_SRC;
                        end
                        else if (last_scan)
                        begin
                            if (!any_reg)
                            begin
                                res_reg       <= '0;
                                res_reg.last  <= 1'b1;
                                res_valid_reg <= 1'b1;
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                            cur_reg <= cur_reg + CW'(1);
                    end
                end
                S_SRC:
                begin
                    // build descriptor from current state, advance source unless it is fixed
                    res_reg <= '0;
                    res_reg.xfer_valid    <= 1'b1;
                    res_reg.channel       <= 2'(cur_reg);
                    res_reg.src_start     <= src_reg[cur_reg];
                    res_reg.src_increment <= sinc;
                    if (fifo_xfer_reg)
                    begin
                        res_reg.beat_count <= 17'd4;
                        res_reg.word_unit  <= 1'b1;
                        res_reg.to_fifo    <= 1'b1;
                    end
                    else
                    begin
                        res_reg.dst_start     <= dst_reg[cur_reg];
                        res_reg.beat_count    <= beats;
                        res_reg.word_unit     <= cword;
                        res_reg.dst_increment <= dinc;
                        res_reg.cycles        <= cword
                            ? 19'({beats, 2'b00} + {1'b0, beats, 1'b0})
                            : 19'({beats, 2'b00});
                    end
                    if (sinc)
                        src_reg[cur_reg] <= add_sum;
                    state_reg <= state_next;
                end
                S_DST:
                begin
                    if (!fifo_xfer_reg)
                    begin
                        if (dc == ADDR_RELOAD)
                            dst_reg[cur_reg] <= rld_reg[cur_reg];
                        else if (dinc)
                            dst_reg[cur_reg] <= add_sum;
                        if (cc[CTRL_REPEAT])
                            cnt_reg[cur_reg] <= crl_reg[cur_reg];
                        else
                        begin
                            cnt_reg[cur_reg] <= beats[15:0];
                            ctl_reg[cur_reg][CTRL_ENABLE] <= 1'b0;
                            en_reg[cur_reg] <= 1'b0;
                        end
                    end
                    // this result is last unless a tick scan has a higher channel firing
                    done_reg  <= imm_reg || fifo_xfer_reg || !later_hit;
                    state_reg <= state_next;
                end
                S_OUT:
                begin
                    if (!res_valid_reg || (out_ch.valid && out_ch.ready))
                    begin
                        res_reg.last  <= done_reg;
                        res_valid_reg <= 1'b1;
                        any_reg       <= 1'b1;
                        if (done_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            cur_reg   <= cur_reg + CW'(1);
                            state_reg <= S_SCAN;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A new word is taken only when no result is pending.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> !res_valid_reg)
        else $error("word accepted with a pending result");
    // An empty result carries no cycle count and no beat count.
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.data.xfer_valid) |-> (out_ch.data.cycles == 19'd0
        && out_ch.data.beat_count == 17'd0))
        else $error("empty result carries descriptor data");
    // FIFO transfers cost nothing and are four beats.
    a_fifo_beats: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.to_fifo) |-> (out_ch.data.beat_count == 17'd4
        && out_ch.data.cycles == 19'd0))
        else $error("bad FIFO descriptor");
`endif

endmodule
